@@ src/bitmap_nearest_upscale_core_macros.svh @@
// Assertion macros shared by the upscaler RTL.
`ifndef BITMAP_NEAREST_UPSCALE_CORE_MACROS_SVH
`define BITMAP_NEAREST_UPSCALE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BNU_ASSERT_ALWAYS(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BNU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/bnu_pkg.sv @@
package bnu_pkg;

	// Pixels packed into one byte, least significant bit first.
	localparam int PIX = 8;

	// Fixed field widths.
	localparam int DIM_W     = 11;
	localparam int STEP_W    = 17;
	localparam int COORD_W   = 10;
	localparam int PROD_W    = 27;
	localparam int BPL_W     = 9;
	localparam int FADDR_W   = 18;
	localparam int CFG_IDX_W = 3;
	localparam int FRAC_W    = 16;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP       = 3'd4;

	// Commands.
	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Reset values and limits.
	localparam logic [DIM_W-1:0]  DIM_RESET = 11'd8;
	localparam logic [STEP_W-1:0] STEP_ONE  = 17'h10000;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [2:0]         bit_idx_t;

	// Where one destination pixel finds its source bit.
	typedef struct packed {
		logic     valid_pix;
		logic     hi_byte;
		bit_idx_t bit_idx;
	} pix_map_t;

endpackage

@@ src/bitmap_nearest_upscale_core.sv @@
// A read transaction passes through stages 1 to 4 and the output register before its result is offered.
// Throughput: one transaction per cycle while the output is not held back; the source store has one write
// port and two read ports, so a byte that straddles two source bytes needs no second access.
// Reset: arst_n clears the pipeline and sets the size registers to 8 and the step to one;
// the source store itself is not cleared and holds undefined data until written.
`include "bitmap_nearest_upscale_core_macros.svh"

module bitmap_nearest_upscale_core
	import bnu_pkg::*;
#(
	parameter int STORE_BYTES = 4096,
	parameter int MAX_DIM     = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [STEP_W-1:0]    cfg_data,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic [11:0]          src_addr,
	input  logic [7:0]           src_data,
	input  logic [9:0]           out_row,
	input  logic [6:0]           out_col_byte,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_data,
	output logic                 in_range
);

	localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

	// A width or height of zero behaves as one, and anything above MAX_DIM is held there.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [31:0] wide;
		wide = {{(32-DIM_W){1'b0}}, v};
		if (v == '0) return DIM_W'(1);
		if (wide > 32'(MAX_DIM)) return DIM_W'(MAX_DIM);
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers. Writes are always accepted; an unknown
	// index is simply dropped.
	// ------------------------------------------------------------------
	logic [DIM_W-1:0]  src_width_q, src_height_q, dst_width_q, dst_height_q;
	logic [STEP_W-1:0] step_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= DIM_RESET;
			src_height_q <= DIM_RESET;
			dst_width_q  <= DIM_RESET;
			dst_height_q <= DIM_RESET;
			step_q       <= STEP_ONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SRC_WIDTH:  src_width_q  <= cfg_data[DIM_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[DIM_W-1:0];
				REG_DST_WIDTH:  dst_width_q  <= cfg_data[DIM_W-1:0];
				REG_DST_HEIGHT: dst_height_q <= cfg_data[DIM_W-1:0];
				REG_STEP:       step_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective sizes. The user must change configuration only while the pipeline is
	// empty (the block does not enforce this), so every stage may use these directly.
	logic [DIM_W-1:0]  sw, sh, dw, dh;
	logic [STEP_W-1:0] st;
	logic [11:0]       bpl_sum;
	logic [BPL_W-1:0]  bpl;

	always_comb begin
		sw = clamp_dim(src_width_q);
		sh = clamp_dim(src_height_q);
		dw = clamp_dim(dst_width_q);
		dh = clamp_dim(dst_height_q);
		if (step_q == '0) begin
			st = STEP_W'(1);
		end else if (step_q > STEP_ONE) begin
			st = STEP_ONE;
		end else begin
			st = step_q;
		end
		// Bytes per source row, rows being padded to whole bytes.
		bpl_sum = {1'b0, sw} + 12'd7;
		bpl     = bpl_sum[11:3];
	end

	// ------------------------------------------------------------------
	// Pipeline flow control. Each stage moves on when the next one is empty
	// or moving itself, so bubbles collapse and a finished result in the
	// output register does not stop the front of the pipeline.
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, out_valid_q;
	logic mv_o, free4, mv4, free3, mv3, free2, mv2;

	assign mv_o     = vld_s4 && (!out_valid_q || out_ready);
	assign free4    = !vld_s4 || mv_o;
	assign mv4      = vld_s3 && free4;
	assign free3    = !vld_s3 || mv4;
	assign mv3      = vld_s2 && free3;
	assign free2    = !vld_s2 || mv3;
	assign mv2      = vld_s1 && free2;
	assign in_ready = !vld_s1 || mv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) vld_s1 <= in_valid;
			if (free2)    vld_s2 <= vld_s1;
			if (free3)    vld_s3 <= vld_s2;
			if (free4)    vld_s4 <= vld_s3;
			if (mv_o) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: captured transaction. The row and the first column of the
	// byte are multiplied by the step here.
	// ------------------------------------------------------------------
	logic         cmd_s1;
	logic [11:0]  addr_s1;
	logic [7:0]   data_s1;
	logic [9:0]   row_s1;
	logic [6:0]   col_s1;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= cmd;
			addr_s1 <= src_addr;
			data_s1 <= src_data;
			row_s1  <= out_row;
			col_s1  <= out_col_byte;
		end
	end

	coord_t            x0_s1;
	logic              rng_s1;
	logic [PROD_W-1:0] prod_y_s1, prod_x_s1;

	always_comb begin
		x0_s1     = {col_s1, 3'b000};
		rng_s1    = ({1'b0, row_s1} < dh) && ({1'b0, x0_s1} < dw);
		prod_y_s1 = PROD_W'(row_s1) * PROD_W'(st);
		prod_x_s1 = PROD_W'(x0_s1) * PROD_W'(st);
	end

	// ------------------------------------------------------------------
	// Stage 2: source row, row base address and the eight source columns.
	// Column b is the first column's product plus b times the step.
	// ------------------------------------------------------------------
	logic              cmd_s2, rng_s2;
	logic [11:0]       addr_s2;
	logic [7:0]        data_s2;
	coord_t            x0_s2;
	logic [PROD_W-1:0] prod_y_s2, prod_x_s2;

	always_ff @(posedge clk) begin
		if (mv2) begin
			cmd_s2    <= cmd_s1;
			rng_s2    <= rng_s1;
			addr_s2   <= addr_s1;
			data_s2   <= data_s1;
			x0_s2     <= x0_s1;
			prod_y_s2 <= prod_y_s1;
			prod_x_s2 <= prod_x_s1;
		end
	end

	coord_t             sy_c2;
	logic [FADDR_W-1:0] base_c2;
	coord_t             sx_c2 [PIX];
	logic [PIX-1:0]     xv_c2;

	assign sy_c2   = prod_y_s2[FRAC_W +: COORD_W];
	assign base_c2 = FADDR_W'(sy_c2) * FADDR_W'(bpl);

	for (genvar b = 0; b < PIX; b++) begin : g_col
		logic [PROD_W-1:0] sum;
		coord_t            xd;
		assign sum      = prod_x_s2 + PROD_W'(st) * PROD_W'(b);
		assign sx_c2[b] = sum[FRAC_W +: COORD_W];
		assign xd       = x0_s2 + COORD_W'(b);
		// Pixels at or beyond the destination width read zero.
		assign xv_c2[b] = {1'b0, xd} < dw;
	end

	// ------------------------------------------------------------------
	// Stage 3: store access. A store writes here and a read fetches the two
	// neighbouring source bytes here, so every access to the store happens
	// at one point in program order and no forwarding is needed.
	// ------------------------------------------------------------------
	logic               cmd_s3, rng_s3;
	logic [11:0]        addr_s3;
	logic [7:0]         data_s3;
	coord_t             sy_s3;
	logic [FADDR_W-1:0] base_s3;
	coord_t             sx_s3 [PIX];
	logic [PIX-1:0]     xv_s3;

	always_ff @(posedge clk) begin
		if (mv3) begin
			cmd_s3  <= cmd_s2;
			rng_s3  <= rng_s2;
			addr_s3 <= addr_s2;
			data_s3 <= data_s2;
			sy_s3   <= sy_c2;
			base_s3 <= base_c2;
			sx_s3   <= sx_c2;
			xv_s3   <= xv_c2;
		end
	end

	logic [FADDR_W-1:0] a0_c3, a1_c3;
	logic               ok0_c3, ok1_c3, sy_ok_c3, wr_en, rd_en;
	pix_map_t           map_c3 [PIX];

	always_comb begin
		a0_c3    = base_s3 + FADDR_W'(sx_s3[0][COORD_W-1:3]);
		a1_c3    = a0_c3 + FADDR_W'(1);
		ok0_c3   = 32'(a0_c3) < 32'(STORE_BYTES);
		ok1_c3   = 32'(a1_c3) < 32'(STORE_BYTES);
		sy_ok_c3 = {1'b0, sy_s3} < sh;
		wr_en    = mv4 && (cmd_s3 == CMD_STORE) && (32'(addr_s3) < 32'(STORE_BYTES));
		rd_en    = mv4 && (cmd_s3 == CMD_READ);
		for (int b = 0; b < PIX; b++) begin
			// The eight source columns span at most two bytes, so the byte
			// is told apart by one address bit.
			map_c3[b].valid_pix = xv_s3[b] && ({1'b0, sx_s3[b]} < sw) && sy_ok_c3;
			map_c3[b].hi_byte   = sx_s3[b][3] ^ sx_s3[0][3];
			map_c3[b].bit_idx   = sx_s3[b][2:0];
		end
	end

	logic [7:0] store_mem [STORE_BYTES];
	logic [7:0] rd0_s4, rd1_s4;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[AW'(addr_s3)] <= data_s3;
		end
		if (rd_en) begin
			rd0_s4 <= store_mem[AW'(a0_c3)];
			rd1_s4 <= store_mem[AW'(a1_c3)];
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: pick each pixel from the fetched bytes and pack the result.
	// ------------------------------------------------------------------
	logic     cmd_s4, rng_s4, ok0_s4, ok1_s4;
	pix_map_t map_s4 [PIX];

	always_ff @(posedge clk) begin
		if (mv4) begin
			cmd_s4 <= cmd_s3;
			rng_s4 <= rng_s3;
			ok0_s4 <= ok0_c3;
			ok1_s4 <= ok1_c3;
			map_s4 <= map_c3;
		end
	end

	logic [PIX-1:0] pix_c4;
	logic           read_hit_c4;

	always_comb begin
		read_hit_c4 = (cmd_s4 == CMD_READ) && rng_s4;
		for (int b = 0; b < PIX; b++) begin
			if (map_s4[b].hi_byte) begin
				pix_c4[b] = map_s4[b].valid_pix && ok1_s4 && rd1_s4[map_s4[b].bit_idx];
			end else begin
				pix_c4[b] = map_s4[b].valid_pix && ok0_s4 && rd0_s4[map_s4[b].bit_idx];
			end
		end
	end

	// Output register. Stores and reads outside the destination answer zero.
	logic [7:0] out_data_q;
	logic       in_range_q;

	always_ff @(posedge clk) begin
		if (mv_o) begin
			out_data_q <= read_hit_c4 ? pix_c4 : 8'd0;
			in_range_q <= read_hit_c4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign in_range  = in_range_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`BNU_ASSERT_ALWAYS(a_stall_only_when_full, clk, arst_n, !in_ready, vld_s1 && vld_s2 && vld_s3 && vld_s4 && out_valid_q && !out_ready, "input stalled with room in the pipeline")
	`BNU_ASSERT_ALWAYS(a_blank_outside, clk, arst_n, out_valid && !in_range, out_data == 8'd0, "non-zero data on a result outside the bitmap")
	`BNU_ASSERT_NEXT(a_fetch_held, clk, arst_n, vld_s4 && !mv_o, vld_s4 && $stable(rd0_s4) && $stable(rd1_s4), "fetched source bytes lost while stalled")

endmodule

@@ tb/bitmap_nearest_upscale_core_tb.sv @@
module bitmap_nearest_upscale_core_tb;
	import bnu_pkg::*;

	// Sizes of the block as instantiated; these match its default parameters.
	localparam int STORE_BYTES = 4096;
	localparam int MAX_DIM     = 1024;
	localparam int STEP_FULL   = 65536;
	// Sets the length of the idle wait before the final verdict.
	localparam int LATENCY     = 4;
	// Indexes above the step register are not decoded by the block.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_STEP + 3'd1;

	// One result transaction as the block should present it.
	typedef struct packed {
		logic [7:0] data;
		logic       in_range;
	} scaled_byte_t;

	// Keeps its own copy of the source bitmap and of the size registers, works out
	// the scaled byte that each accepted command should produce, and compares the
	// results in order of acceptance.
	class scaled_byte_predictor;
		logic [7:0]        src_bytes [STORE_BYTES];
		bit                seeded [STORE_BYTES];
		logic [DIM_W-1:0]  src_w, src_h, dst_w, dst_h;
		logic [STEP_W-1:0] step_q;
		scaled_byte_t      expected_bytes [$];
		int                errors;

		function new();
			src_w  = DIM_RESET;
			src_h  = DIM_RESET;
			dst_w  = DIM_RESET;
			dst_h  = DIM_RESET;
			step_q = STEP_ONE;
			errors = 0;
			foreach (seeded[i])
				seeded[i] = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] value);
			case (idx)
			REG_SRC_WIDTH:  src_w  = value[DIM_W-1:0];
			REG_SRC_HEIGHT: src_h  = value[DIM_W-1:0];
			REG_DST_WIDTH:  dst_w  = value[DIM_W-1:0];
			REG_DST_HEIGHT: dst_h  = value[DIM_W-1:0];
			REG_STEP:       step_q = value;
			default: ;
			endcase
		endfunction

		// A size of zero behaves as one, and anything above the maximum as the maximum.
		function int clamp_dim(logic [DIM_W-1:0] v);
			if (v == 0)
				return 1;
			if (int'(v) > MAX_DIM)
				return MAX_DIM;
			return int'(v);
		endfunction

		function int eff_step();
			if (step_q == 0)
				return 1;
			if (int'(step_q) > STEP_FULL)
				return STEP_FULL;
			return int'(step_q);
		endfunction

		function int dst_rows();
			return clamp_dim(dst_h);
		endfunction

		function int dst_cols();
			return (clamp_dim(dst_w) + PIX - 1) / PIX;
		endfunction

		// Bytes of the store that the current source bitmap occupies.
		function int source_span();
			int span;
			span = ((clamp_dim(src_w) + PIX - 1) / PIX) * clamp_dim(src_h);
			return (span > STORE_BYTES) ? STORE_BYTES : span;
		endfunction

		function bit in_dest(int row, int col);
			return row < dst_rows() && col * PIX < clamp_dim(dst_w);
		endfunction

		// Bit position in the store of the source pixel behind destination pixel (x, y),
		// or -1 where the pixel falls outside the source bitmap or the store.
		function int source_bit(int x, int y);
			int sw, sh, st, sx, sy, addr;
			sw = clamp_dim(src_w);
			sh = clamp_dim(src_h);
			st = eff_step();
			sx = int'((longint'(x) * longint'(st)) >> FRAC_W);
			sy = int'((longint'(y) * longint'(st)) >> FRAC_W);
			if (sx >= sw || sy >= sh)
				return -1;
			addr = sy * ((sw + PIX - 1) / PIX) + sx / PIX;
			if (addr >= STORE_BYTES)
				return -1;
			return addr * PIX + sx % PIX;
		endfunction

		// First store byte that a read would touch before it has been written, or -1.
		function int first_unseeded(int row, int col);
			int b, x, p;
			if (!in_dest(row, col))
				return -1;
			for (b = 0; b < PIX; b++) begin
				x = col * PIX + b;
				if (x >= clamp_dim(dst_w))
					break;
				p = source_bit(x, row);
				if (p >= 0 && !seeded[p / PIX])
					return p / PIX;
			end
			return -1;
		endfunction

		function void note_command(logic c, logic [11:0] addr, logic [7:0] data,
			int row, int col);
			scaled_byte_t e;
			int b, x, p;
			e = '0;
			if (c == CMD_STORE) begin
				src_bytes[addr] = data;
				seeded[addr] = 1'b1;
			end else if (in_dest(row, col)) begin
				e.in_range = 1'b1;
				for (b = 0; b < PIX; b++) begin
					x = col * PIX + b;
					if (x >= clamp_dim(dst_w))
						break;
					p = source_bit(x, row);
					if (p >= 0)
						e.data[b] = src_bytes[p / PIX][p % PIX];
				end
			end
			expected_bytes.push_back(e);
		endfunction

		function void check_byte(logic [7:0] data, logic hit);
			scaled_byte_t e;
			if (expected_bytes.size() == 0) begin
				$display("%0t: result with nothing outstanding, out_data %02h in_range %0b",
					$time, data, hit);
				errors++;
			end else begin
				e = expected_bytes.pop_front();
				if (data !== e.data) begin
					$display("%0t: out_data expected %02h actual %02h", $time, e.data, data);
					errors++;
				end
				if (hit !== e.in_range) begin
					$display("%0t: in_range expected %0b actual %0b", $time, e.in_range, hit);
					errors++;
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [STEP_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 cmd;
	logic [11:0]          src_addr;
	logic [7:0]           src_data;
	logic [9:0]           out_row;
	logic [6:0]           out_col_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [7:0]           out_data;
	logic                 in_range;

	// Chance, in per cent, that the sender or the receiver holds back in a cycle.
	int send_idle_pct;
	int recv_idle_pct;

	scaled_byte_predictor pred;

	bitmap_nearest_upscale_core #(
		.STORE_BYTES (STORE_BYTES),
		.MAX_DIM     (MAX_DIM)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.src_addr     (src_addr),
		.src_data     (src_data),
		.out_row      (out_row),
		.out_col_byte (out_col_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.in_range     (in_range)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side. Outputs are sampled straight after the edge, so the values seen are
	// those the block presented at the edge. A completed transaction is checked against
	// the oldest expectation, and ready is redrawn for the next cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			pred.check_byte(out_data, in_range);
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Offers one command, idling beforehand at random, and holds it until the block
	// takes it. Valid stays high when the next command follows without a gap.
	task automatic send_item(logic c, logic [11:0] addr, logic [7:0] data,
		logic [9:0] row, logic [6:0] col);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		src_addr     <= addr;
		src_data     <= data;
		out_row      <= row;
		out_col_byte <= col;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred.note_command(c, addr, data, int'(row), int'(col));
	endtask

	// The store is undefined until written, so any byte a read would reach is given
	// random contents first. The unused fields of every command carry random values.
	task automatic read_byte(int row, int col);
		int a;
		a = pred.first_unseeded(row, col);
		while (a >= 0) begin
			send_item(CMD_STORE, 12'(a), 8'($urandom_range(255)), 10'($urandom_range(1023)),
				7'($urandom_range(127)));
			a = pred.first_unseeded(row, col);
		end
		send_item(CMD_READ, 12'($urandom_range(4095)), 8'($urandom_range(255)), 10'(row),
			7'(col));
	endtask

	// Stops offering commands and waits until every expected result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pred.expected_bytes.size() != 0);
	endtask

	// Register writes within one batch follow one another with valid left high.
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		pred.write_reg(idx, value);
	endtask

	task automatic configure(int sw, int sh, int dw, int dh, int st);
		cfg_write(REG_SRC_WIDTH, STEP_W'(sw));
		cfg_write(REG_SRC_HEIGHT, STEP_W'(sh));
		cfg_write(REG_DST_WIDTH, STEP_W'(dw));
		cfg_write(REG_DST_HEIGHT, STEP_W'(dh));
		cfg_write(REG_STEP, STEP_W'(st));
		// Writes to the undecoded indexes must leave every register as it was.
		if ($urandom_range(1))
			cfg_write(CFG_IDX_W'(REG_SPARE_FIRST + $urandom_range(2)),
				STEP_W'($urandom_range(STEP_FULL * 2 - 1)));
		cfg_valid <= 1'b0;
	endtask

	// Sizes kept small so that reads land inside the source bitmap most of the time;
	// the destination follows from the step as it would in real use.
	task automatic configure_random();
		int sw, sh, st;
		sw = $urandom_range(24, 1);
		sh = $urandom_range(24, 1);
		st = $urandom_range(STEP_FULL, 8192);
		configure(sw, sh, (sw * STEP_FULL) / st, (sh * STEP_FULL) / st, st);
	endtask

	// Random traffic for one register setting: roughly a third are stores, mostly into
	// the region the source bitmap uses, and most reads fall inside the destination.
	// Halfway through, the sender holds off until the block has nothing in flight.
	task automatic run_phase(int n_items);
		int k, span;
		for (k = 0; k < n_items; k++) begin
			if (k == n_items / 2)
				wait_drained();
			if ($urandom_range(99) < 30) begin
				span = pred.source_span();
				send_item(CMD_STORE,
					12'(($urandom_range(99) < 70) ? $urandom_range(span - 1)
						: $urandom_range(4095)),
					8'($urandom_range(255)), 10'($urandom_range(1023)),
					7'($urandom_range(127)));
			end else if ($urandom_range(99) < 85) begin
				read_byte($urandom_range(pred.dst_rows() - 1), $urandom_range(pred.dst_cols() - 1));
			end else begin
				read_byte($urandom_range(1023), $urandom_range(127));
			end
		end
		wait_drained();
	endtask

	initial begin
		pred = new();
		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= REG_SRC_WIDTH;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		cmd          <= CMD_STORE;
		src_addr     <= '0;
		src_data     <= '0;
		out_row      <= '0;
		out_col_byte <= '0;
		out_ready    <= 1'b0;
		send_idle_pct = 29;
		recv_idle_pct = 52;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset setting: an 8 by 8 bitmap copied one to one, so
		// each row is exactly one store byte. Rows get distinctive patterns, the last
		// store address and the data extremes are written, then every row is read back,
		// followed by reads just past the bottom edge, just past the right edge and at
		// the far corner of the address range.
		send_item(CMD_STORE, 12'd0, 8'h00, 10'd0, 7'd0);
		send_item(CMD_STORE, 12'd1, 8'hFF, 10'd0, 7'd0);
		send_item(CMD_STORE, 12'd2, 8'hA5, 10'd0, 7'd0);
		send_item(CMD_STORE, 12'd3, 8'h5A, 10'd0, 7'd0);
		send_item(CMD_STORE, 12'd4, 8'h01, 10'd0, 7'd0);
		send_item(CMD_STORE, 12'd5, 8'h80, 10'd0, 7'd0);
		send_item(CMD_STORE, 12'd6, 8'h3C, 10'd0, 7'd0);
		send_item(CMD_STORE, 12'd7, 8'hC3, 10'd0, 7'd0);
		send_item(CMD_STORE, 12'd4095, 8'hFF, 10'h3FF, 7'h7F);
		for (int r = 0; r < 8; r++)
			read_byte(r, 0);
		read_byte(8, 0);
		read_byte(0, 1);
		read_byte(1023, 127);
		wait_drained();

		// First part of the run: the sender idles now and then, the receiver often.
		configure(8, 8, 16, 16, STEP_FULL / 2);
		run_phase(200);
		// Destination wider and taller than the scaled source, with a source width that is
		// not a whole number of bytes, so source coordinates run off the bitmap.
		configure(5, 3, 40, 9, STEP_FULL);
		run_phase(200);
		// Largest bitmap: most source rows lie beyond the end of the store.
		configure(MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM, STEP_FULL);
		run_phase(200);

		// Second part: the idle rates are swapped, and out-of-range register values
		// are checked to behave as their clamped equivalents.
		send_idle_pct = 52;
		recv_idle_pct = 29;
		configure(0, 0, 0, 0, 0);
		run_phase(120);
		configure(2047, 2047, 2047, 2047, STEP_FULL * 2 - 1);
		run_phase(200);
		configure(1, 1, 1, 1, 1);
		run_phase(120);

		// Last part: both sides run flat out.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure(12, 10, 37, 29, 21257);
		run_phase(180);
		configure_random();
		run_phase(180);
		configure_random();
		run_phase(180);

		wait_drained();
		repeat (LATENCY * 4) @(posedge clk);
		if (pred.errors == 0 && pred.expected_bytes.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Guard against a hung handshake: far longer than even the slowest correct run.
	initial begin
		#5000000;
		$display("tb: failure");
		$finish;
	end

endmodule
